FILE: hw/rtl/sli_pkg.sv
// Shared constants and types for the sorted list intersection block.
// No dependencies; compiled first.

package sli_pkg;

   // Field widths of the request and response transactions
   localparam int MODE_WIDTH = 2;
   localparam int ID_WIDTH   = 31;

   // Default depth of each id store
   localparam int LIST_DEPTH_DEFAULT = 64;

   // Request mode codes
   localparam logic [MODE_WIDTH-1:0] MODE_LOAD_FIRST  = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_LOAD_SECOND = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_RUN         = 2'd2;

   // One response transaction
   typedef struct packed {
      logic [ID_WIDTH-1:0] match_id;
      logic                last;
      logic                none_found;
      logic                overflow;
   } sli_result_type;

endpackage

FILE: hw/rtl/sli_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on sli_pkg for field widths.

interface sli_req_if import sli_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [MODE_WIDTH-1:0] mode;
   logic [ID_WIDTH-1:0]   doc_id;

   modport source (output valid, output mode, output doc_id, input ready);
   modport sink   (input valid, input mode, input doc_id, output ready);
endinterface

interface sli_rsp_if import sli_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ID_WIDTH-1:0] match_id;
   logic                last;
   logic                none_found;
   logic                overflow;

   modport source (output valid, output match_id, output last, output none_found,
                   output overflow, input ready);
   modport sink   (input valid, input match_id, input last, input none_found,
                   input overflow, output ready);
endinterface

FILE: hw/rtl/sli_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module sli_ram #(
   parameter int WIDTH      = 31,
   parameter int DEPTH      = 64,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/sorted_list_intersection.sv
// Sorted list intersection: load transactions append ids to the two stores.
// A run walks both stores with one shared comparator; each pointer step passes
// through a read state, which reads both store RAMs together, and a compare
// state, and a run can wait on a stalled response side.
// Results leave through a one-entry output register; the final one follows the walk.
// Reset clears counts, dropped flag and control; the stores are not cleared.

module sorted_list_intersection import sli_pkg::*; #(
   parameter int LIST_DEPTH = LIST_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   sli_req_if.sink      req_bus,
   sli_rsp_if.source    rsp_bus
);

   localparam int ADDR_WIDTH  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(LIST_DEPTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_CMP  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   localparam logic [COUNT_WIDTH-1:0] DEPTH_COUNT = COUNT_WIDTH'(LIST_DEPTH);

   logic [1:0]             state_ff, state_in;
   logic [COUNT_WIDTH-1:0] first_count_ff, first_count_in;
   logic [COUNT_WIDTH-1:0] second_count_ff, second_count_in;
   logic                   dropped_ff, dropped_in;
   logic [COUNT_WIDTH-1:0] first_ptr_ff, first_ptr_in;
   logic [COUNT_WIDTH-1:0] second_ptr_ff, second_ptr_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [ID_WIDTH-1:0]    pend_id_ff, pend_id_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sli_result_type         rsp_data_ff, rsp_data_in;

   logic                   req_take;
   logic                   first_wr, second_wr;
   logic [ID_WIDTH-1:0]    first_rd, second_rd;
   logic                   ids_equal, first_lower;
   logic                   out_free;
   logic                   push;
   sli_result_type         push_data;
   logic [COUNT_WIDTH-1:0] first_step, second_step;

   // Id stores
   sli_ram #(
      .WIDTH      (ID_WIDTH),
      .DEPTH      (LIST_DEPTH),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_first_store (
      .clock   (clock),
      .wr_en   (first_wr),
      .wr_addr (first_count_ff[ADDR_WIDTH-1:0]),
      .wr_data (req_bus.doc_id),
      .rd_addr (first_ptr_ff[ADDR_WIDTH-1:0]),
      .rd_data (first_rd)
   );

   sli_ram #(
      .WIDTH      (ID_WIDTH),
      .DEPTH      (LIST_DEPTH),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_second_store (
      .clock   (clock),
      .wr_en   (second_wr),
      .wr_addr (second_count_ff[ADDR_WIDTH-1:0]),
      .wr_data (req_bus.doc_id),
      .rd_addr (second_ptr_ff[ADDR_WIDTH-1:0]),
      .rd_data (second_rd)
   );

   // Handshake
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   assign first_wr  = req_take && (req_bus.mode == MODE_LOAD_FIRST)
                      && (first_count_ff < DEPTH_COUNT);
   assign second_wr = req_take && (req_bus.mode == MODE_LOAD_SECOND)
                      && (second_count_ff < DEPTH_COUNT);

   // Shared comparator
   assign ids_equal   = (first_rd == second_rd);
   assign first_lower = (first_rd < second_rd);

   assign first_step  = first_ptr_ff + 1'b1;
   assign second_step = second_ptr_ff + 1'b1;

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      dropped_in      = dropped_ff;
      first_ptr_in    = first_ptr_ff;
      second_ptr_in   = second_ptr_ff;
      pend_valid_in   = pend_valid_ff;
      pend_id_in      = pend_id_ff;
      push            = 1'b0;
      push_data       = '{match_id: pend_id_ff, last: 1'b0, none_found: 1'b0,
                          overflow: dropped_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               priority if (req_bus.mode == MODE_LOAD_FIRST) begin
                  if (first_wr) begin
                     first_count_in = first_count_ff + 1'b1;
                  end else begin
                     dropped_in = 1'b1;
                  end
               end else if (req_bus.mode == MODE_LOAD_SECOND) begin
                  if (second_wr) begin
                     second_count_in = second_count_ff + 1'b1;
                  end else begin
                     dropped_in = 1'b1;
                  end
               end else if (req_bus.mode == MODE_RUN) begin
                  first_ptr_in  = '0;
                  second_ptr_in = '0;
                  pend_valid_in = 1'b0;
                  if ((first_count_ff == '0) || (second_count_ff == '0)) begin
                     state_in = ST_FIN;
                  end else begin
                     state_in = ST_READ;
                  end
               end else begin
                  // unused mode: nothing happens
               end
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (ids_equal) begin
               // earlier match leaves only when a later one proves it is not last
               if (!pend_valid_ff || out_free) begin
                  push          = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_id_in    = first_rd;
                  first_ptr_in  = first_step;
                  second_ptr_in = second_step;
               end
            end else if (first_lower) begin
               first_ptr_in = first_step;
            end else begin
               second_ptr_in = second_step;
            end
            if ((first_ptr_in != first_ptr_ff) || (second_ptr_in != second_ptr_ff)) begin
               if ((first_ptr_in >= first_count_ff) || (second_ptr_in >= second_count_ff)) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_FIN: begin
            if (out_free) begin
               push = 1'b1;
               if (pend_valid_ff) begin
                  push_data.last = 1'b1;
               end else begin
                  push_data = '{match_id: '0, last: 1'b1, none_found: 1'b1,
                                overflow: dropped_ff};
               end
               pend_valid_in   = 1'b0;
               first_count_in  = '0;
               second_count_in = '0;
               dropped_in      = 1'b0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = push_data;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         dropped_ff      <= 1'b0;
         first_ptr_ff    <= '0;
         second_ptr_ff   <= '0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         dropped_ff      <= dropped_in;
         first_ptr_ff    <= first_ptr_in;
         second_ptr_ff   <= second_ptr_in;
         pend_valid_ff   <= pend_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_id_ff  <= pend_id_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.match_id   = rsp_data_ff.match_id;
   assign rsp_bus.last       = rsp_data_ff.last;
   assign rsp_bus.none_found = rsp_data_ff.none_found;
   assign rsp_bus.overflow   = rsp_data_ff.overflow;

`ifndef NO_ASSERTIONS
   // Store counts never pass the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (first_count_ff <= DEPTH_COUNT) && (second_count_ff <= DEPTH_COUNT))
      else $error("store count beyond depth");

   // Compare cycles only read written entries
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |->
         (first_ptr_ff < first_count_ff) && (second_ptr_ff < second_count_ff))
      else $error("walk pointer beyond loaded entries");

   // Closing a run empties both stores and the dropped flag
   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FIN) && out_free) |=>
         (first_count_ff == '0) && (second_count_ff == '0) && !dropped_ff
         && (state_ff == ST_IDLE))
      else $error("run did not clear stores");

   // An empty result is the only and final result of its run
   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.none_found) |->
         rsp_data_ff.last && (rsp_data_ff.match_id == '0))
      else $error("none_found result not final or nonzero");

   // A match leaving the pending slot is never the final one
   a_pending_push: assert property (@(posedge clock) disable iff (reset)
      (push && (state_ff == ST_CMP)) |=> rsp_valid_ff && !rsp_data_ff.last && pend_valid_ff)
      else $error("pending match pushed incorrectly");
`endif

endmodule
